FILE: rtl/scd_pkg.sv
// Shared types, codes and constants for the short/long click detector.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package scd_pkg;

  // Widths
  localparam int TIME_BITS = 16;                 // elapsed counter width
  localparam int CFG_W     = 16;                 // threshold register width
  localparam int CMP_W     = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
  localparam int REQ_W     = 2;
  localparam int SND_W     = 2;
  localparam int PH_W      = 3;
  localparam int IDX_W     = 2;
  localparam int STEP_MAX  = 7;                  // phases one tick may pass through

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ARM  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_STOP = 2'd2;

  // Phase codes
  localparam logic [PH_W-1:0] PH_IDLE     = 3'd0;
  localparam logic [PH_W-1:0] PH_RELEASED = 3'd1;
  localparam logic [PH_W-1:0] PH_GAP      = 3'd2;
  localparam logic [PH_W-1:0] PH_SHORT    = 3'd3;
  localparam logic [PH_W-1:0] PH_LONG     = 3'd4;
  localparam logic [PH_W-1:0] PH_WAITREL  = 3'd5;

  // Sound request codes
  localparam logic [SND_W-1:0] SND_NONE  = 2'd0;
  localparam logic [SND_W-1:0] SND_SHORT = 2'd1;
  localparam logic [SND_W-1:0] SND_LONG  = 2'd2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] CFG_GAP   = 2'd0;
  localparam logic [IDX_W-1:0] CFG_SHORT = 2'd1;
  localparam logic [IDX_W-1:0] CFG_LONG  = 2'd2;

  // Configuration reset values
  localparam logic [CFG_W-1:0] GAP_RST   = 16'd50;
  localparam logic [CFG_W-1:0] SHORT_RST = 16'd500;
  localparam logic [CFG_W-1:0] LONG_RST  = 16'd2000;

  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  typedef struct packed {
    logic [CFG_W-1:0] gap_ticks;
    logic [CFG_W-1:0] short_ticks;
    logic [CFG_W-1:0] long_ticks;
  } cfg_t;

  typedef struct packed {
    logic [PH_W-1:0]      phase;
    logic [TIME_BITS-1:0] elapsed;
    logic                 want_long;
    logic                 want_short;
    logic                 short_flag;
    logic                 long_flag;
    logic [SND_W-1:0]     sound;
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/scd_if.sv
// Valid/ready channel interfaces of the click detector: request, result
// and configuration write. Depends on scd_pkg.
`default_nettype none

interface scd_req_if;
  import scd_pkg::*;
  logic             valid;
  logic             ready;
  logic [REQ_W-1:0] req_type;
  logic             button_level;
  logic             arm_long;
  logic             arm_short;

  modport source (output valid, req_type, button_level, arm_long, arm_short,
                  input ready);
  modport sink   (input valid, req_type, button_level, arm_long, arm_short,
                  output ready);
endinterface

interface scd_rsp_if;
  import scd_pkg::*;
  logic             valid;
  logic             ready;
  logic [SND_W-1:0] sound_cmd;
  logic             short_seen;
  logic             long_seen;
  logic [PH_W-1:0]  phase_now;

  modport source (output valid, sound_cmd, short_seen, long_seen, phase_now,
                  input ready);
  modport sink   (input valid, sound_cmd, short_seen, long_seen, phase_now,
                  output ready);
endinterface

interface scd_cfg_if;
  import scd_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  logic [CFG_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/scd_cfg_regs.sv
// Threshold registers of the click detector, written over the config channel.
// Depends on scd_pkg and scd_cfg_if.
`default_nettype none

module scd_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  scd_cfg_if.sink          cfg,
  output scd_pkg::cfg_t    regs
);
  import scd_pkg::*;

  // Writes should land only while the block is idle; the block does not enforce this, and the port never stalls
  assign cfg.ready = 1'b1;

  // Register file; an index past the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.gap_ticks   <= GAP_RST;
      regs.short_ticks <= SHORT_RST;
      regs.long_ticks  <= LONG_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_GAP:   regs.gap_ticks   <= cfg.data;
        CFG_SHORT: regs.short_ticks <= cfg.data;
        CFG_LONG:  regs.long_ticks  <= cfg.data;
        default:   ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/scd_step.sv
// Next-state logic for one request: arm, stop, or a tick that walks the
// press-timing phases. Purely combinational. Depends on scd_pkg.
`default_nettype none

module scd_step (
  input  wire scd_pkg::state_t         cur,
  input  wire scd_pkg::cfg_t           regs,
  input  wire logic [scd_pkg::REQ_W-1:0] req_type,
  input  wire logic                    button_level,
  input  wire logic                    arm_long,
  input  wire logic                    arm_short,
  output scd_pkg::state_t              nxt
);
  import scd_pkg::*;

  logic                 armed;
  logic                 timing;
  logic                 zero_path;
  logic [TIME_BITS-1:0] e_run;
  logic [TIME_BITS-1:0] e_eff;
  logic                 lt_gap;
  logic                 lt_short;
  logic                 lt_long;
  logic [PH_W-1:0]      ph;
  logic [SND_W-1:0]     snd;
  logic                 sflag;
  logic                 lflag;
  logic                 done;

  assign armed  = cur.want_long | cur.want_short;
  assign timing = (cur.phase == PH_GAP) || (cur.phase == PH_SHORT) ||
                  (cur.phase == PH_LONG);

  // Saturating tick count while a press is being timed
  assign e_run = (timing && (cur.elapsed != TIME_MAX)) ?
                 cur.elapsed + TIME_BITS'(1) : cur.elapsed;

  // A new press starts only from released (or idle when armed); the count
  // restarts at zero and the gap phase sees zero
  assign zero_path = button_level &&
                     ((cur.phase == PH_RELEASED) || ((cur.phase == PH_IDLE) && armed));
  assign e_eff     = zero_path ? '0 : e_run;

  // The count stays fixed for the rest of the tick, so compare once
  assign lt_gap   = CMP_W'(e_eff) < CMP_W'(regs.gap_ticks);
  assign lt_short = CMP_W'(e_eff) < CMP_W'(regs.short_ticks);
  assign lt_long  = CMP_W'(e_eff) < CMP_W'(regs.long_ticks);

  // Phase walk for a tick; a few steps on narrow state
  always_comb begin
    ph    = cur.phase;
    snd   = cur.sound;
    sflag = cur.short_flag;
    lflag = cur.long_flag;
    done  = 1'b0;
    for (int i = 0; i < STEP_MAX; i++) begin
      if (!done) begin
        case (ph)
          PH_IDLE: begin
            if (!armed) done = 1'b1;
            else ph = PH_RELEASED;
          end
          PH_RELEASED: begin
            if (button_level) begin
              ph = PH_GAP;
            end else begin
              if (!armed) ph = PH_IDLE;
              done = 1'b1;
            end
          end
          PH_GAP: begin
            if (lt_gap) begin
              if (!armed) begin
                ph   = PH_IDLE;
                done = 1'b1;
              end else if (!button_level) begin
                ph = PH_RELEASED;
              end else begin
                done = 1'b1;
              end
            end else begin
              snd = SND_SHORT;
              ph  = PH_SHORT;
            end
          end
          PH_SHORT: begin
            if (lt_short) begin
              if (!armed) begin
                snd = SND_NONE;
                ph  = PH_WAITREL;
              end else if (!button_level && cur.want_short) begin
                snd   = SND_NONE;
                sflag = 1'b1;
                ph    = PH_RELEASED;
              end else begin
                // disabled short release keeps timing
                done = 1'b1;
              end
            end else begin
              snd = SND_LONG;
              ph  = PH_LONG;
            end
          end
          PH_LONG: begin
            if (lt_long) begin
              if (!armed) begin
                snd = SND_NONE;
                ph  = PH_WAITREL;
              end else if (!button_level) begin
                if (cur.want_long) begin
                  snd   = SND_NONE;
                  lflag = 1'b1;
                end
                ph = PH_RELEASED;
              end else begin
                done = 1'b1;
              end
            end else begin
              snd = SND_NONE;
              ph  = PH_WAITREL;
            end
          end
          PH_WAITREL: begin
            if (button_level) done = 1'b1;
            else ph = PH_IDLE;
          end
          default: begin
            ph   = PH_IDLE;
            done = 1'b1;
          end
        endcase
      end
    end
  end

  // Request decode
  always_comb begin
    nxt = cur;
    case (req_type)
      REQ_TICK: begin
        nxt.phase      = ph;
        nxt.elapsed    = e_eff;
        nxt.sound      = snd;
        nxt.short_flag = sflag;
        nxt.long_flag  = lflag;
      end
      REQ_ARM: begin
        nxt.want_long  = arm_long;
        nxt.want_short = arm_short;
      end
      REQ_STOP: begin
        nxt.want_long  = 1'b0;
        nxt.want_short = 1'b0;
        nxt.short_flag = 1'b0;
        nxt.long_flag  = 1'b0;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/short_long_click_detector.sv
// Short/long click detector. Each request (millisecond tick with the button
// level, arm with short/long enables, or stop) produces exactly one result
// carrying the current sound request, the latched short and long click flags
// and the timing phase. One request is taken every clock cycle unless the
// result side stalls; a request is held in the input register and its result
// is then written to the result register. The next-state logic is
// combinational and resolves all phase changes of a tick together. While a
// result waits, a new request is still taken if the input register is empty.
// The user must write thresholds over the cfg channel (index 0 gap, 1
// short window end, 2 long window end) only while idle; the block does not
// enforce it. Depends on scd_pkg, scd_if, scd_cfg_regs and scd_step.
`default_nettype none

module short_long_click_detector (
  input  wire logic clk,
  input  wire logic rst,
  scd_cfg_if.sink   cfg,
  scd_req_if.sink   req,
  scd_rsp_if.source rsp
);
  import scd_pkg::*;

  cfg_t              regs;
  state_t            st;
  state_t            st_next;
  logic              stg_valid;
  logic [REQ_W-1:0]  stg_req_type;
  logic              stg_button;
  logic              stg_arm_long;
  logic              stg_arm_short;
  logic              out_free;
  logic              advance;

  scd_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  scd_step u_step (
    .cur          (st),
    .regs         (regs),
    .req_type     (stg_req_type),
    .button_level (stg_button),
    .arm_long     (stg_arm_long),
    .arm_short    (stg_arm_short),
    .nxt          (st_next)
  );

  // Handshake
  assign out_free  = !rsp.valid || rsp.ready;
  assign advance   = stg_valid && out_free;
  assign req.ready = !stg_valid || out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (req.ready) begin
      stg_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stg_req_type  <= req.req_type;
      stg_button    <= req.button_level;
      stg_arm_long  <= req.arm_long;
      stg_arm_short <= req.arm_short;
    end
  end

  // Detector state, updated as each request moves to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= PH_IDLE;
      st.elapsed    <= '0;
      st.want_long  <= 1'b0;
      st.want_short <= 1'b0;
      st.short_flag <= 1'b0;
      st.long_flag  <= 1'b0;
      st.sound      <= SND_NONE;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_free) begin
      rsp.valid <= stg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.sound_cmd  <= st_next.sound;
      rsp.short_seen <= st_next.short_flag;
      rsp.long_seen  <= st_next.long_flag;
      rsp.phase_now  <= st_next.phase;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/scd_checker.sv
// Port-level checks for the click detector and the bind that attaches them.
// Depends on scd_pkg and short_long_click_detector.
`default_nettype none

module scd_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      rsp_valid,
  input wire logic                      rsp_ready,
  input wire logic [scd_pkg::SND_W-1:0] sound_cmd,
  input wire logic                      short_seen,
  input wire logic                      long_seen,
  input wire logic [scd_pkg::PH_W-1:0]  phase_now
);
  import scd_pkg::*;

  // No result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(sound_cmd) &&
      $stable(short_seen) && $stable(long_seen) && $stable(phase_now))
    else $error("stalled result changed");

  // Short window always sounds the short click
  a_short_sound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (phase_now == PH_SHORT) |-> sound_cmd == SND_SHORT)
    else $error("short window without short sound");

  // Long window sounds the long click; waiting for release is silent
  a_long_sound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && ((phase_now == PH_LONG) || (phase_now == PH_WAITREL)) |->
      ((phase_now == PH_LONG) && (sound_cmd == SND_LONG)) ||
      ((phase_now == PH_WAITREL) && (sound_cmd == SND_NONE)))
    else $error("sound does not match long or wait phase");

endmodule

bind short_long_click_detector scd_checker u_scd_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .sound_cmd  (rsp.sound_cmd),
  .short_seen (rsp.short_seen),
  .long_seen  (rsp.long_seen),
  .phase_now  (rsp.phase_now)
);

`default_nettype wire

FILE: test/tb_short_long_click_detector.sv
// Testbench for the short/long click detector: drives requests and threshold
// writes, predicts every result and checks it. Depends on scd_pkg, scd_if
// and the short_long_click_detector RTL.
`timescale 1ns / 1ps

module tb_short_long_click_detector;
  import scd_pkg::*;

  // Spare request code: the block reports its state and changes nothing
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [SND_W-1:0] sound;
    logic             short_seen;
    logic             long_seen;
    logic [PH_W-1:0]  phase;
  } click_result_t;

  // Click predictor plus queue of expected results
  class click_scoreboard;
    logic [CFG_W-1:0]     gap_lim, short_lim, long_lim;
    logic [PH_W-1:0]      ph;
    logic [TIME_BITS-1:0] held;
    bit                   en_long, en_short, short_hit, long_hit;
    logic [SND_W-1:0]     snd;
    click_result_t        pending[$];
    int                   mismatches;

    function new();
      gap_lim    = GAP_RST;
      short_lim  = SHORT_RST;
      long_lim   = LONG_RST;
      ph         = PH_IDLE;
      held       = '0;
      en_long    = 1'b0;
      en_short   = 1'b0;
      short_hit  = 1'b0;
      long_hit   = 1'b0;
      snd        = SND_NONE;
      mismatches = 0;
    endfunction

    function void set_threshold(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_GAP:   gap_lim = val;
        CFG_SHORT: short_lim = val;
        CFG_LONG:  long_lim = val;
        default: ;
      endcase
    endfunction

    // One millisecond tick; may walk through several phases
    function void step_tick(bit pressed);
      bit armed;
      bit done;
      int hops;
      armed = en_long | en_short;
      if ((ph == PH_GAP || ph == PH_SHORT || ph == PH_LONG) && held != TIME_MAX)
        held++;
      done = 1'b0;
      for (hops = 0; hops < 12 && !done; hops++) begin
        case (ph)
          PH_IDLE: begin
            if (!armed) done = 1'b1;
            else ph = PH_RELEASED;
          end
          PH_RELEASED: begin
            if (pressed) begin
              held = '0;
              ph = PH_GAP;
            end else begin
              if (!armed) ph = PH_IDLE;
              done = 1'b1;
            end
          end
          PH_GAP: begin
            if (held < gap_lim) begin
              if (!armed) begin
                ph = PH_IDLE;
                done = 1'b1;
              end else if (!pressed) begin
                ph = PH_RELEASED;
              end else begin
                done = 1'b1;
              end
            end else begin
              snd = SND_SHORT;
              ph = PH_SHORT;
            end
          end
          PH_SHORT: begin
            if (held < short_lim) begin
              if (!armed) begin
                snd = SND_NONE;
                ph = PH_WAITREL;
              end else if (!pressed && en_short) begin
                snd = SND_NONE;
                short_hit = 1'b1;
                ph = PH_RELEASED;
              end else begin
                // a release with short clicks disabled keeps timing
                done = 1'b1;
              end
            end else begin
              snd = SND_LONG;
              ph = PH_LONG;
            end
          end
          PH_LONG: begin
            if (held < long_lim) begin
              if (!armed) begin
                snd = SND_NONE;
                ph = PH_WAITREL;
              end else if (!pressed) begin
                if (en_long) begin
                  snd = SND_NONE;
                  long_hit = 1'b1;
                end
                ph = PH_RELEASED;
              end else begin
                done = 1'b1;
              end
            end else begin
              snd = SND_NONE;
              ph = PH_WAITREL;
            end
          end
          PH_WAITREL: begin
            if (pressed) done = 1'b1;
            else ph = PH_IDLE;
          end
          default: begin
            ph = PH_IDLE;
            done = 1'b1;
          end
        endcase
      end
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, bit lvl, bit al, bit as);
      click_result_t exp_res;
      case (kind)
        REQ_TICK: step_tick(lvl);
        REQ_ARM: begin
          en_long = al;
          en_short = as;
        end
        REQ_STOP: begin
          en_long = 1'b0;
          en_short = 1'b0;
          short_hit = 1'b0;
          long_hit = 1'b0;
        end
        default: ;
      endcase
      exp_res.sound = snd;
      exp_res.short_seen = short_hit;
      exp_res.long_seen = long_hit;
      exp_res.phase = ph;
      pending.push_back(exp_res);
    endfunction

    function void check_result(click_result_t got);
      click_result_t exp_res;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: snd=%0d short=%0b long=%0b phase=%0d",
                   got.sound, got.short_seen, got.long_seen, got.phase);
        return;
      end
      exp_res = pending.pop_front();
      if (got !== exp_res) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp snd=%0d short=%0b long=%0b phase=%0d, ",
                    "got snd=%0d short=%0b long=%0b phase=%0d"},
                   exp_res.sound, exp_res.short_seen, exp_res.long_seen,
                   exp_res.phase, got.sound, got.short_seen, got.long_seen,
                   got.phase);
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction

    function bit failed();
      return (mismatches != 0) || (pending.size() != 0);
    endfunction
  endclass

  logic clk;
  logic rst;
  scd_req_if req_ch();
  scd_rsp_if rsp_ch();
  scd_cfg_if cfg_ch();

  click_scoreboard sb;
  int idle_max;
  int items_sent;

  short_long_click_detector u_dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Safety net against a hung handshake
  initial begin
    #1_000_000;
    $display("** short_long_click_detector: FAILED **");
    $finish;
  end

  function automatic bit rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // One request transfer, after a random hold-off
  task automatic send_req(input logic [REQ_W-1:0] kind, input bit lvl, input bit al,
                          input bit as);
    int pause;
    pause = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
    if (pause > 0) begin
      req_ch.valid = 1'b0;
      repeat (pause) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.req_type = kind;
    req_ch.button_level = lvl;
    req_ch.arm_long = al;
    req_ch.arm_short = as;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sb.note_request(kind, lvl, al, as);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic tick(input bit lvl);
    send_req(REQ_TICK, lvl, rand_bit(), rand_bit());
  endtask

  // Stray request: arm, stop, spare code or a random tick
  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_req(REQ_ARM, rand_bit(), rand_bit(), rand_bit());
      1: send_req(REQ_STOP, rand_bit(), rand_bit(), rand_bit());
      2: send_req(REQ_UNUSED, rand_bit(), rand_bit(), rand_bit());
      default: tick(rand_bit());
    endcase
  endtask

  // Press for some ticks, then release for some ticks
  task automatic press_release(input int hold, input int rel, input bit noisy);
    int i;
    for (i = 0; i < hold; i++) begin
      if (noisy && $urandom_range(0, 15) == 0) send_noise();
      tick(1'b1);
    end
    for (i = 0; i < rel; i++) tick(1'b0);
  endtask

  // Hold off until every result is back, then let the pipeline empty
  task automatic drain();
    req_ch.valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write all three thresholds back to back
  task automatic write_thresholds(input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] s,
                                  input logic [CFG_W-1:0] l);
    logic [CFG_W-1:0] vals[3];
    int i;
    vals[0] = g;
    vals[1] = s;
    vals[2] = l;
    for (i = 0; i < 3; i++) begin
      cfg_ch.valid = 1'b1;
      cfg_ch.index = (i == 0) ? CFG_GAP : (i == 1) ? CFG_SHORT : CFG_LONG;
      cfg_ch.data = vals[i];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      sb.set_threshold(cfg_ch.index, vals[i]);
      @(negedge clk);
    end
    cfg_ch.valid = 1'b0;
  endtask

  // Result side: random stall per result, check on each transfer
  initial begin
    int stall;
    click_result_t got;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
      if (stall > 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      got.sound = rsp_ch.sound_cmd;
      got.short_seen = rsp_ch.short_seen;
      got.long_seen = rsp_ch.long_seen;
      got.phase = rsp_ch.phase_now;
      sb.check_result(got);
      @(negedge clk);
    end
  end

  // Stimulus
  initial begin
    int phase_no;
    int clicks;
    int c;
    int hold;
    logic [CFG_W-1:0] g, s, l;
    bit al, as;

    sb = new();
    idle_max = 10;
    items_sent = 0;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_TICK;
    req_ch.button_level = 1'b0;
    req_ch.arm_long = 1'b0;
    req_ch.arm_short = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_GAP;
    cfg_ch.data = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Reset thresholds: spare code, unarmed ticks, stop, then real clicks
    send_req(REQ_UNUSED, 1'b1, 1'b1, 1'b1);
    tick(1'b0);
    tick(1'b1);
    send_req(REQ_STOP, 1'b1, 1'b1, 1'b1);
    send_req(REQ_ARM, 1'b0, 1'b1, 1'b1);
    idle_max = 0;
    press_release(55, 2, 1'b0);    // short click
    press_release(20, 1, 1'b0);    // too brief, ignored
    idle_max = 10;
    drain();

    // Directed walk through the windows with tiny thresholds
    write_thresholds(16'd2, 16'd4, 16'd6);
    send_req(REQ_ARM, 1'b1, 1'b1, 1'b1);
    press_release(3, 1, 1'b0);     // short click commits
    send_req(REQ_STOP, 1'b0, 1'b0, 1'b0);
    send_req(REQ_ARM, 1'b0, 1'b1, 1'b0);
    press_release(3, 1, 1'b0);     // release ignored, short clicks disabled
    tick(1'b1);                    // reaches the long window
    tick(1'b0);                    // long click commits
    tick(1'b1);
    send_req(REQ_STOP, 1'b1, 1'b0, 1'b0);
    tick(1'b1);                    // disarmed in gap: back to idle
    send_req(REQ_ARM, 1'b0, 1'b0, 1'b1);
    press_release(3, 0, 1'b0);
    send_req(REQ_STOP, 1'b0, 1'b1, 1'b1);
    press_release(2, 1, 1'b0);     // disarmed in short window: wait release
    drain();

    // Random phases
    phase_no = 0;
    while (items_sent < 420) begin
      if (phase_no == 0) begin
        g = '0;
        s = '0;
        l = '0;
      end else if ($urandom_range(0, 4) == 0) begin
        g = CFG_W'($urandom_range(0, 20));
        s = CFG_W'($urandom_range(0, 20));
        l = CFG_W'($urandom_range(0, 20));
      end else begin
        g = CFG_W'($urandom_range(0, 6));
        s = CFG_W'(g + $urandom_range(0, 10));
        l = CFG_W'(s + $urandom_range(0, 12));
      end
      write_thresholds(g, s, l);
      idle_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
      al = rand_bit();
      as = rand_bit();
      if (!al && !as && $urandom_range(0, 5) != 0) al = 1'b1;
      send_req(REQ_ARM, rand_bit(), al, as);
      clicks = $urandom_range(3, 8);
      for (c = 0; c < clicks; c++) begin
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 2))
            0: hold = int'(g);
            1: hold = int'(s);
            default: hold = int'(l);
          endcase
          hold = hold + $urandom_range(0, 2);
          if (hold > 0 && $urandom_range(0, 1) == 0) hold = hold - 1;
        end else begin
          hold = $urandom_range(0, l + 3);
        end
        press_release(hold, $urandom_range(1, 4), 1'b1);
        if ($urandom_range(0, 6) == 0) send_noise();
      end
      if ($urandom_range(0, 3) == 0) send_req(REQ_STOP, 1'b0, 1'b0, 1'b0);
      idle_max = 10;
      drain();
      phase_no++;
    end

    // All thresholds at maximum: a press stays in the gap phase
    write_thresholds('1, '1, '1);
    send_req(REQ_ARM, 1'b1, 1'b1, 1'b1);
    press_release(12, 2, 1'b0);

    drain();
    if (sb.outstanding() != 0)
      $display("results still missing: %0d", sb.outstanding());
    if (!sb.failed()) begin
      $display("** short_long_click_detector: PASSED **");
    end else begin
      $display("** short_long_click_detector: FAILED **");
    end
    $finish;
  end

endmodule

FILE: short_long_click_detector.f
rtl/scd_pkg.sv
rtl/scd_if.sv
rtl/scd_cfg_regs.sv
rtl/scd_step.sv
rtl/short_long_click_detector.sv
rtl/scd_checker.sv
test/tb_short_long_click_detector.sv
